>>> rtl/core/epv_pkg.sv
// Shared types, codes and opcode classifier for the eBPF program verifier.
`default_nettype none
package epv_pkg;

   localparam int MAX_PROGRAM_DEF = 4096;
   localparam int QUEUE_DEPTH     = 4;
   localparam int LIMIT_W         = 13;
   localparam int INDEX_W         = 12;
   localparam logic [LIMIT_W-1:0] CALL_LIMIT_RST = 13'd16;

   // instruction kinds
   localparam logic [2:0] K_BAD    = 3'd0;
   localparam logic [2:0] K_PLAIN  = 3'd1;
   localparam logic [2:0] K_ENDIAN = 3'd2;
   localparam logic [2:0] K_STORE  = 3'd3;
   localparam logic [2:0] K_LDDW   = 3'd4;
   localparam logic [2:0] K_JUMP   = 3'd5;
   localparam logic [2:0] K_CALL   = 3'd6;
   localparam logic [2:0] K_DIVIMM = 3'd7;

   // error codes
   localparam logic [3:0] ERR_NONE    = 4'd0;
   localparam logic [3:0] ERR_TOOLONG = 4'd1;
   localparam logic [3:0] ERR_ENDIAN  = 4'd2;
   localparam logic [3:0] ERR_LDDW    = 4'd3;
   localparam logic [3:0] ERR_LOOP    = 4'd4;
   localparam logic [3:0] ERR_BOUNDS  = 4'd5;
   localparam logic [3:0] ERR_MIDLDDW = 4'd6;
   localparam logic [3:0] ERR_CALL    = 4'd7;
   localparam logic [3:0] ERR_DIVZERO = 4'd8;
   localparam logic [3:0] ERR_OPCODE  = 4'd9;
   localparam logic [3:0] ERR_SRC     = 4'd10;
   localparam logic [3:0] ERR_DST     = 4'd11;

   typedef struct packed {
      logic [7:0]         opcode;
      logic [3:0]         dst_reg;
      logic [3:0]         src_reg;
      logic signed [15:0] jump_offset;
      logic signed [31:0] immediate;
      logic               last;
   } req_type;

   typedef struct packed {
      logic                valid_res;
      logic [3:0]          error_code;
      logic [INDEX_W-1:0]  error_index;
   } rsp_type;

   // word layout: imm[63:32] off[31:16] src[15:12] dst[11:8] op[7:0]
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] imm;
      logic [15:0] off;
      logic [3:0]  src;
      logic [3:0]  dst;
      logic [7:0]  op;
   } store_type;

   typedef struct packed {
      logic      last;
      store_type data;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
   } queue_ctl_type;

   function automatic logic [2:0] classify(input logic [7:0] op);
      logic [2:0] cls;
      logic [3:0] hi;
      logic       reg_src;
      logic [2:0] k;
      cls     = op[2:0];
      hi      = op[7:4];
      reg_src = op[3];
      k       = K_BAD;
      if (cls == 3'd4 || cls == 3'd7) begin
         if (hi <= 4'hc) begin
            if (hi == 4'h8) k = reg_src ? K_BAD : K_PLAIN;
            else if ((hi == 4'h3 || hi == 4'h9) && !reg_src) k = K_DIVIMM;
            else k = K_PLAIN;
         end else if (hi == 4'hd && cls == 3'd4) begin
            k = K_ENDIAN;
         end
      end else if (cls == 3'd5) begin
         if (hi == 4'h0) k = reg_src ? K_BAD : K_JUMP;
         else if (hi == 4'h8) k = reg_src ? K_BAD : K_CALL;
         else if (hi == 4'h9) k = reg_src ? K_BAD : K_PLAIN;
         else if (hi <= 4'hd) k = K_JUMP;
      end else begin
         unique case (op)
            8'h61, 8'h69, 8'h71, 8'h79: k = K_PLAIN;
            8'h62, 8'h6a, 8'h72, 8'h7a,
            8'h63, 8'h6b, 8'h73, 8'h7b: k = K_STORE;
            8'h18:                      k = K_LDDW;
            default:                    k = K_BAD;
         endcase
      end
      return k;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/epv_front.sv
// Front end: accepts instruction beats, classifies the opcode, pushes to the queue.
`default_nettype none
module epv_front (
   input  wire epv_pkg::req_type   req_data,
   input  wire logic               start,
   input  wire logic               queue_full,
   output logic                    busy,
   output logic                    push,
   output epv_pkg::entry_type      push_data
);
   assign busy = queue_full;
   assign push = start && !queue_full;

   always_comb begin
      push_data.last      = req_data.last;
      push_data.data.kind = epv_pkg::classify(req_data.opcode);
      push_data.data.imm  = req_data.immediate;
      push_data.data.off  = req_data.jump_offset;
      push_data.data.src  = req_data.src_reg;
      push_data.data.dst  = req_data.dst_reg;
      push_data.data.op   = req_data.opcode;
   end
endmodule
`default_nettype wire

>>> rtl/core/epv_queue.sv
// Short FIFO between front end and walker.
`default_nettype none
module epv_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire epv_pkg::queue_ctl_type ctl,
   input  wire epv_pkg::entry_type   push_data,
   output epv_pkg::entry_type        pop_data,
   output logic                      full,
   output logic                      empty
);
   localparam int PW = $clog2(epv_pkg::QUEUE_DEPTH);

   epv_pkg::entry_type slot_ff [epv_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PW+1)'(epv_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (ctl.push) wptr_in = wptr_ff + 1'b1;
      if (ctl.pop)  rptr_in = rptr_ff + 1'b1;
      if (ctl.push && !ctl.pop) cnt_in = cnt_ff + 1'b1;
      else if (!ctl.push && ctl.pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (ctl.push) slot_ff[wptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

>>> rtl/core/epv_back.sv
// Back end: program store, walk sequencer and verdict register.
`default_nettype none
module epv_back #(
   parameter int MAX_PROGRAM = epv_pkg::MAX_PROGRAM_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          empty,
   input  wire epv_pkg::entry_type            pop_data,
   output logic                               pop,
   input  wire logic [epv_pkg::LIMIT_W-1:0]   call_limit,
   output logic                               rsp_valid,
   output epv_pkg::rsp_type                   rsp_data
);
   localparam int AW  = (MAX_PROGRAM > 1) ? $clog2(MAX_PROGRAM) : 1;
   localparam int CW  = AW + 1;
   localparam int XW  = (AW > epv_pkg::INDEX_W) ? AW : epv_pkg::INDEX_W;
   localparam int TW  = (CW + 1 > 18) ? CW + 1 : 18;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_ISSUE = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_EVAL2 = 3'd4;

   epv_pkg::store_type mem [MAX_PROGRAM];
   epv_pkg::store_type rd_a_ff, rd_b_ff;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] walk_ff, walk_in, addr_b;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          wr_en;
   logic          rsp_valid_ff, rsp_valid_in;
   epv_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] nxt1, nxt2, step;
   logic signed [TW-1:0] target;
   logic [3:0]    reg_err, code;
   logic          finish, advance, use2;
   logic [XW-1:0] idx_wide;

   assign nxt1     = {1'b0, walk_ff} + CW'(1);
   assign nxt2     = {1'b0, walk_ff} + CW'(2);
   assign target   = $signed(TW'({1'b0, walk_ff})) + TW'(1)
                   + TW'($signed(rd_a_ff.off));
   assign idx_wide = XW'(walk_ff);

   // register field checks, done after the kind-specific ones
   always_comb begin
      reg_err = epv_pkg::ERR_NONE;
      if (rd_a_ff.src > 4'd10) reg_err = epv_pkg::ERR_SRC;
      else if (rd_a_ff.dst > 4'd9 &&
               !(rd_a_ff.kind == epv_pkg::K_STORE && rd_a_ff.dst == 4'd10))
         reg_err = epv_pkg::ERR_DST;
   end

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      addr_b       = walk_ff;
      finish       = 1'b0;
      advance      = 1'b0;
      use2         = 1'b0;
      code         = epv_pkg::ERR_NONE;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (!empty) begin
               pop = 1'b1;
               if (count_ff < CW'(MAX_PROGRAM)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (pop_data.last) state_in = S_START;
            end
         end
         S_START: begin
            // walk_ff is zero here, so rd_a_ff holds entry 0 next cycle
            if (ovf_ff || count_ff == CW'(MAX_PROGRAM)) begin
               finish = 1'b1;
               code   = epv_pkg::ERR_TOOLONG;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_ISSUE: state_in = S_EVAL;
         S_EVAL: begin
            case (rd_a_ff.kind)
               epv_pkg::K_ENDIAN: begin
                  if (rd_a_ff.imm != 32'd16 && rd_a_ff.imm != 32'd32 &&
                      rd_a_ff.imm != 32'd64) begin
                     finish = 1'b1;
                     code   = epv_pkg::ERR_ENDIAN;
                  end else advance = 1'b1;
               end
               epv_pkg::K_LDDW: begin
                  if (nxt1 >= count_ff) begin
                     finish = 1'b1;
                     code   = epv_pkg::ERR_LDDW;
                  end else begin
                     addr_b   = nxt1[AW-1:0];
                     state_in = S_EVAL2;
                  end
               end
               epv_pkg::K_JUMP: begin
                  if (rd_a_ff.off == 16'hffff) begin
                     finish = 1'b1;
                     code   = epv_pkg::ERR_LOOP;
                  end else if (target < 0 || target >= $signed(TW'(count_ff))) begin
                     finish = 1'b1;
                     code   = epv_pkg::ERR_BOUNDS;
                  end else begin
                     addr_b   = target[AW-1:0];
                     state_in = S_EVAL2;
                  end
               end
               epv_pkg::K_CALL: begin
                  if (rd_a_ff.imm[31] ||
                      rd_a_ff.imm >= 32'(call_limit)) begin
                     finish = 1'b1;
                     code   = epv_pkg::ERR_CALL;
                  end else advance = 1'b1;
               end
               epv_pkg::K_DIVIMM: begin
                  if (rd_a_ff.imm == 32'd0) begin
                     finish = 1'b1;
                     code   = epv_pkg::ERR_DIVZERO;
                  end else advance = 1'b1;
               end
               epv_pkg::K_BAD: begin
                  finish = 1'b1;
                  code   = epv_pkg::ERR_OPCODE;
               end
               default: advance = 1'b1;
            endcase
         end
         S_EVAL2: begin
            if (rd_a_ff.kind == epv_pkg::K_LDDW) begin
               if (rd_b_ff.op != 8'd0) begin
                  finish = 1'b1;
                  code   = epv_pkg::ERR_LDDW;
               end else begin
                  advance = 1'b1;
                  use2    = 1'b1;
               end
            end else if (rd_b_ff.op == 8'd0) begin
               finish = 1'b1;
               code   = epv_pkg::ERR_MIDLDDW;
            end else advance = 1'b1;
         end
         default: state_in = S_LOAD;
      endcase

      step = use2 ? nxt2 : nxt1;
      if (advance) begin
         if (reg_err != epv_pkg::ERR_NONE) begin
            finish = 1'b1;
            code   = reg_err;
         end else if (step >= count_ff) begin
            finish = 1'b1;
            code   = epv_pkg::ERR_NONE;
         end else begin
            walk_in  = step[AW-1:0];
            state_in = S_ISSUE;
         end
      end

      if (finish) begin
         rsp_valid_in          = 1'b1;
         rsp_in.valid_res      = (code == epv_pkg::ERR_NONE);
         rsp_in.error_code     = code;
         rsp_in.error_index    = (code == epv_pkg::ERR_NONE ||
                                  code == epv_pkg::ERR_TOOLONG)
                               ? '0 : idx_wide[epv_pkg::INDEX_W-1:0];
         count_in = '0;
         ovf_in   = 1'b0;
         walk_in  = '0;
         state_in = S_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         walk_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // program store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) mem[count_ff[AW-1:0]] <= pop_data.data;
      rd_a_ff <= mem[walk_ff];
      rd_b_ff <= mem[addr_b];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/core/ebpf_program_verifier.sv
// Top level of the eBPF program verifier.
// Instructions are taken one per cycle (start high, busy low) into a four-beat
// queue and written into the program store at one per cycle while loading; the
// beat with last set closes the program. The walker then reads the store through
// two ports in issue and evaluate states, plus a second evaluate state for jumps
// and wide loads, before the verdict appears on rsp_data for one cycle with
// rsp_valid; busy stays high while the queue is full during the walk. The receiver
// cannot stall, so the verdict must be captured in that cycle. The user must write
// call_limit via csr_valid/csr_data only while idle (not enforced). It resets to 16.
`default_nettype none
module ebpf_program_verifier #(
   parameter int MAX_PROGRAM = epv_pkg::MAX_PROGRAM_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire epv_pkg::req_type             req_data,
   output logic                              rsp_valid,
   output epv_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [epv_pkg::LIMIT_W-1:0]  csr_data
);
   logic [epv_pkg::LIMIT_W-1:0] call_limit_ff, call_limit_in;
   epv_pkg::queue_ctl_type ctl;
   epv_pkg::entry_type     push_data, pop_data;
   logic full, empty, push, pop;

   assign csr_ready     = 1'b1;
   assign call_limit_in = (csr_valid && csr_ready) ? csr_data : call_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) call_limit_ff <= epv_pkg::CALL_LIMIT_RST;
      else       call_limit_ff <= call_limit_in;
   end

   assign ctl.push = push;
   assign ctl.pop  = pop;

   epv_front u_front (
      .req_data   (req_data),
      .start      (start),
      .queue_full (full),
      .busy       (busy),
      .push       (push),
      .push_data  (push_data)
   );

   epv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .push_data (push_data),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   epv_back #(.MAX_PROGRAM(MAX_PROGRAM)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .call_limit (call_limit_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire

>>> rtl/core/epv_checker.sv
// Port-level assertions for the verifier, bound to the top level.
`default_nettype none
module epv_port_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire epv_pkg::rsp_type rsp_data
);
   // a verdict needs at least a load beat between two strobes
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back verdict strobes");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy)) else $error("outputs active after reset");

   a_valid_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.valid_res == (rsp_data.error_code == epv_pkg::ERR_NONE)))
      else $error("valid_res disagrees with error_code");

   a_valid_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.valid_res || rsp_data.error_code == epv_pkg::ERR_TOOLONG))
      |-> (rsp_data.error_index == '0)) else $error("nonzero index without location");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_code <= epv_pkg::ERR_DST))
      else $error("error code out of range");
endmodule

bind ebpf_program_verifier epv_port_checker u_epv_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> verif/epv_checker.sv
// Watches the verifier's channels, predicts each verdict and compares it.
`timescale 1ns / 100ps
module epv_checker
   import epv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire req_type            req_data,
   input  wire logic               rsp_valid,
   input  wire rsp_type            rsp_data,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_data,
   output int                      pending,
   output int                      failures
);

   localparam int STORE_DEPTH = MAX_PROGRAM_DEF;

   logic [63:0]        prog_mem [0:STORE_DEPTH-1];
   int                 prog_len;
   bit                 prog_overflow;
   logic [LIMIT_W-1:0] call_lim;
   rsp_type            verdict_q [$];
   int                 mismatches;

   assign pending  = verdict_q.size();
   assign failures = mismatches;

   function automatic logic [2:0] kind_of(input logic [7:0] op);
      logic [3:0] hi;
      hi = op[7:4];
      case (op[2:0])
         3'd4, 3'd7: begin
            if (hi == 4'h8) return op[3] ? K_BAD : K_PLAIN;
            if (hi == 4'h3 || hi == 4'h9) return op[3] ? K_PLAIN : K_DIVIMM;
            if (hi <= 4'hc) return K_PLAIN;
            if (hi == 4'hd && op[2:0] == 3'd4) return K_ENDIAN;
            return K_BAD;
         end
         3'd5: begin
            case (hi)
               4'h0:    return op[3] ? K_BAD : K_JUMP;
               4'h8:    return op[3] ? K_BAD : K_CALL;
               4'h9:    return op[3] ? K_BAD : K_PLAIN;
               4'he,
               4'hf:    return K_BAD;
               default: return K_JUMP;
            endcase
         end
         default: begin
            if (op inside {8'h61, 8'h69, 8'h71, 8'h79}) return K_PLAIN;
            if (op inside {8'h62, 8'h6a, 8'h72, 8'h7a, 8'h63, 8'h6b, 8'h73, 8'h7b})
               return K_STORE;
            if (op == 8'h18) return K_LDDW;
            return K_BAD;
         end
      endcase
   endfunction

   function automatic rsp_type judge_program();
      rsp_type            v;
      int                 n;
      int                 i;
      int                 tgt;
      int                 skip;
      logic [63:0]        w;
      logic [2:0]         k;
      logic signed [15:0] off;
      logic signed [31:0] imm;
      logic [3:0]         code;
      n    = prog_len;
      code = ERR_NONE;
      v    = '0;
      if (prog_overflow || n >= STORE_DEPTH) begin
         v.error_code = ERR_TOOLONG;
         return v;
      end
      i = 0;
      while (i < n && code == ERR_NONE) begin
         skip = 0;
         w   = prog_mem[i];
         k   = kind_of(w[7:0]);
         off = w[31:16];
         imm = w[63:32];
         case (k)
            K_ENDIAN: if (imm != 16 && imm != 32 && imm != 64) code = ERR_ENDIAN;
            K_LDDW: begin
               if (i + 1 >= n || prog_mem[i+1][7:0] != 8'h00) code = ERR_LDDW;
               else skip = 1;
            end
            K_JUMP: begin
               tgt = i + 1 + int'(off);
               if (off == -1) code = ERR_LOOP;
               else if (tgt < 0 || tgt >= n) code = ERR_BOUNDS;
               else if (prog_mem[tgt][7:0] == 8'h00) code = ERR_MIDLDDW;
            end
            K_CALL:   if (imm < 0 || longint'(imm) >= longint'(call_lim)) code = ERR_CALL;
            K_DIVIMM: if (imm == 0) code = ERR_DIVZERO;
            K_BAD:    code = ERR_OPCODE;
            default: ;
         endcase
         if (code == ERR_NONE) begin
            if (w[15:12] > 4'd10) code = ERR_SRC;
            else if (w[11:8] > 4'd9 && !(k == K_STORE && w[11:8] == 4'd10)) code = ERR_DST;
         end
         // on an error the index stays on the failing slot
         if (code == ERR_NONE) i += 1 + skip;
      end
      v.error_code = code;
      if (code == ERR_NONE) v.valid_res = 1'b1;
      else v.error_index = i[INDEX_W-1:0];
      return v;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         verdict_q.delete();
         prog_len      = 0;
         prog_overflow = 0;
         call_lim      = CALL_LIMIT_RST;
         mismatches    = 0;
      end else begin
         if (csr_valid && csr_ready) call_lim = csr_data;
         if (rsp_valid) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: verdict with none expected: valid=%0d code=%0d index=%0d",
                           $realtime, rsp_data.valid_res, rsp_data.error_code,
                           rsp_data.error_index);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: verdict exp valid=%0d code=%0d index=%0d, got %0d %0d %0d",
                              $realtime, want.valid_res, want.error_code, want.error_index,
                              rsp_data.valid_res, rsp_data.error_code, rsp_data.error_index);
               end
            end
         end
         if (start && !busy) begin
            if (prog_len < STORE_DEPTH) begin
               prog_mem[prog_len] = {req_data.immediate, req_data.jump_offset,
                                     req_data.src_reg, req_data.dst_reg, req_data.opcode};
               prog_len++;
            end else begin
               prog_overflow = 1;
            end
            if (req_data.last) begin
               verdict_q.push_back(judge_program());
               prog_len      = 0;
               prog_overflow = 0;
            end
         end
      end
   end

endmodule

>>> verif/tb_ebpf_program_verifier.sv
// Stimulus and verdict for the eBPF program verifier.
`timescale 1ns / 100ps
module tb_ebpf_program_verifier;
   import epv_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_data = '0;
   int                 pending;
   int                 failures;
   int                 cycles = 0;
   int                 sent = 0;
   bit                 quiet;
   logic [LIMIT_W-1:0] cur_limit = CALL_LIMIT_RST;

   always #5 clock = ~clock;

   ebpf_program_verifier dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   epv_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .pending(pending), .failures(failures)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ebpf_program_verifier] ERROR");
         $finish;
      end
   end

   function automatic req_type instr(input logic [7:0] op, input logic [3:0] d,
                                     input logic [3:0] s, input logic [15:0] off,
                                     input logic [31:0] imm, input bit fin);
      req_type r;
      r = '{opcode: op, dst_reg: d, src_reg: s, jump_offset: off, immediate: imm, last: fin};
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat
   task automatic push_beat(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sent++;
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      int n;
      if (quiet || $urandom_range(0, 3) != 0) return;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_limit  = v;
   endtask

   function automatic logic [3:0] pick_reg(input int top);
      return ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'($urandom_range(0, top));
   endfunction

   // mostly legal instruction with random content, sometimes broken
   function automatic req_type random_instr(input int i, input int n);
      req_type     r;
      logic [2:0]  cls;
      logic [3:0]  hi;
      r        = '0;
      r.dst_reg = pick_reg(9);
      r.src_reg = pick_reg(10);
      r.jump_offset = 16'($urandom);
      r.immediate   = $urandom;
      cls = $urandom_range(0, 1) ? 3'd4 : 3'd7;
      case ($urandom_range(0, 9))
         0: begin
            hi = 4'($urandom_range(0, 12));
            r.opcode = {hi, (hi == 4'h8) ? 1'b0 : 1'($urandom), cls};
         end
         1: begin
            r.opcode = {4'hd, 1'($urandom), 3'd4};
            case ($urandom_range(0, 3))
               0: r.immediate = 16;
               1: r.immediate = 32;
               2: r.immediate = 64;
               default: ;
            endcase
         end
         2: r.opcode = 8'h61 + 8'(8 * $urandom_range(0, 3));
         3: begin
            r.opcode = (8'h62 + 8'($urandom_range(0, 1))) + 8'(8 * $urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) r.dst_reg = 4'd10;
         end
         4: r.opcode = 8'h18;
         5: begin
            hi = 4'($urandom_range(0, 13));
            if (hi == 4'h8 || hi == 4'h9) hi = 4'h1;
            r.opcode = {hi, (hi == 4'h0) ? 1'b0 : 1'($urandom), 3'd5};
            if ($urandom_range(0, 7) != 0)
               r.jump_offset = 16'($urandom_range(0, n - 1) - i - 1);
         end
         6: begin
            r.opcode = 8'h85;
            if ($urandom_range(0, 5) != 0)
               r.immediate = $urandom_range(0, cur_limit + 1);
         end
         7: r.opcode = 8'h95;
         8: begin
            r.opcode = {$urandom_range(0, 1) ? 4'h3 : 4'h9, 1'b0, cls};
            if ($urandom_range(0, 4) == 0) r.immediate = 0;
         end
         default: r.opcode = 8'($urandom);
      endcase
      return r;
   endfunction

   task automatic random_program();
      int      n;
      req_type r;
      n     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
         r = ($urandom_range(0, 19) == 0) ? req_type'({1'($urandom), $urandom, $urandom})
                                          : random_instr(i, n);
         r.last = (i == n - 1);
         push_beat(r);
         // second half of a wide load usually follows with a zero opcode
         if (r.opcode == 8'h18 && i + 1 < n && $urandom_range(0, 7) != 0) begin
            i++;
            r        = req_type'({1'($urandom), $urandom, $urandom});
            r.opcode = 8'h00;
            r.last   = (i == n - 1);
            push_beat(r);
         end
         maybe_gap();
      end
   endtask

   int lims [5];

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed single-instruction and short programs
      push_beat(instr(8'h95, 0, 0, 0, 0, 1));
      push_beat(instr(8'hdc, 1, 0, 0, 24, 1));
      push_beat(instr(8'hd4, 1, 0, 0, 64, 1));
      push_beat(instr(8'h18, 1, 0, 0, 0, 1));
      push_beat(instr(8'h05, 0, 0, 16'hffff, 0, 1));
      push_beat(instr(8'h05, 0, 0, 16'h7fff, 0, 1));
      push_beat(instr(8'h1d, 1, 2, 16'h8000, 0, 1));
      push_beat(instr(8'h18, 1, 0, 0, 5, 0));
      push_beat(instr(8'h00, 0, 0, 0, 7, 0));
      push_beat(instr(8'h05, 0, 0, 16'hfffe, 0, 1));
      push_beat(instr(8'h85, 0, 0, 0, 16, 1));
      push_beat(instr(8'h85, 0, 0, 0, 32'hffffffff, 1));
      push_beat(instr(8'h85, 0, 0, 0, 15, 1));
      push_beat(instr(8'h34, 1, 0, 0, 0, 1));
      push_beat(instr(8'h00, 0, 0, 0, 0, 1));
      push_beat(instr(8'hff, 15, 15, 16'hffff, 32'hffffffff, 1));
      push_beat(instr(8'hb7, 1, 11, 0, 0, 1));
      push_beat(instr(8'h62, 10, 0, 0, 0, 1));
      push_beat(instr(8'hb7, 10, 0, 0, 0, 1));
      push_beat(instr(8'hb7, 15, 10, 0, 32'h7fffffff, 1));
      push_beat(instr(8'hb7, 9, 10, 16'h7fff, 32'h80000000, 1));
      push_beat(instr(8'hdc, 1, 0, 0, 16, 1));

      lims = '{0, 4096, 1, 16, $urandom_range(2, 40)};
      foreach (lims[p]) begin
         write_limit(LIMIT_W'(lims[p]));
         sent = 0;
         while (sent < 350) random_program();
      end

      drain();
      repeat (50) @(negedge clock);
      if (failures == 0) $display("[ebpf_program_verifier] OK");
      else $display("[ebpf_program_verifier] ERROR");
      $finish;
   end

endmodule
